// ===== sv/ps2mct_pkg.sv =====
// shared types and constants for the ps/2 mouse cursor tracker
package ps2mct_pkg;

    localparam int unsigned POS_W     = 10;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd1;

    localparam logic [POS_W-1:0] RESET_MAX_X = 10'd1020;
    localparam logic [POS_W-1:0] RESET_MAX_Y = 10'd760;
    localparam logic [POS_W-1:0] RESET_POS_X = 10'd512;
    localparam logic [POS_W-1:0] RESET_POS_Y = 10'd384;

    localparam int unsigned SYNC_BIT = 3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_DELTA_X = 2'd1,
        PH_DELTA_Y = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              from_mouse;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic             left_button;
    } out_item_t;

endpackage

// ===== sv/ps2mct_in_stage.sv =====
// input register stage holding one item for the packet logic
module ps2mct_in_stage
    import ps2mct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     s1_valid,
    output in_item_t s1_item,
    input  logic     s1_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign in_ready = !valid_reg || s1_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

// ===== sv/ps2mct_core.sv =====
// packet assembly, cursor update with clamping, and limit registers
module ps2mct_core
    import ps2mct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    input  logic                 s1_valid,
    input  in_item_t             s1_item,
    output logic                 s1_take,
    input  logic                 buf_full,
    output logic                 push,
    output out_item_t            result
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] header_next;
    logic [BYTE_W-1:0] dx_reg;
    logic [BYTE_W-1:0] dx_next;
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_x_next;
    logic [POS_W-1:0]  pos_y_reg;
    logic [POS_W-1:0]  pos_y_next;
    logic [POS_W-1:0]  max_x_reg;
    logic [POS_W-1:0]  max_y_reg;

    logic              needs_push;
    logic              fire;
    logic              sync;
    logic signed [POS_W+1:0] sum_x;
    logic signed [POS_W+1:0] sum_y;
    logic [POS_W-1:0]  clamp_x;
    logic [POS_W-1:0]  clamp_y;

    assign cfg_ready  = 1'b1;
    assign needs_push = s1_item.from_mouse && (phase_reg == PH_DELTA_Y);
    // items that give no result never wait on the output buffer
    assign s1_take    = s1_valid && (!needs_push || !buf_full);
    assign fire       = s1_take && s1_item.from_mouse;
    assign sync       = s1_item.data_byte[SYNC_BIT];

    // 12-bit signed sums cover -128 .. 1151
    assign sum_x = $signed({2'b00, pos_x_reg})
                 + $signed({{(POS_W+2-BYTE_W){dx_reg[BYTE_W-1]}}, dx_reg});
    assign sum_y = $signed({2'b00, pos_y_reg})
                 - $signed({{(POS_W+2-BYTE_W){s1_item.data_byte[BYTE_W-1]}},
                            s1_item.data_byte});

    always_comb
    begin
        priority if (sum_x[POS_W+1])
        begin
            clamp_x = '0;
        end
        else if (sum_x[POS_W:0] > {1'b0, max_x_reg})
        begin
            clamp_x = max_x_reg;
        end
        else
        begin
            clamp_x = sum_x[POS_W-1:0];
        end
    end

    always_comb
    begin
        priority if (sum_y[POS_W+1])
        begin
            clamp_y = '0;
        end
        else if (sum_y[POS_W:0] > {1'b0, max_y_reg})
        begin
            clamp_y = max_y_reg;
        end
        else
        begin
            clamp_y = sum_y[POS_W-1:0];
        end
    end

    // next packet phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:  phase_next = sync ? PH_DELTA_X : PH_HEADER;
                PH_DELTA_X: phase_next = PH_DELTA_Y;
                PH_DELTA_Y: phase_next = PH_HEADER;
                default:    phase_next = sync ? PH_DELTA_X : PH_HEADER;
            endcase
        end
    end

    // data captured and results produced per phase
    always_comb
    begin
        header_next = header_reg;
        dx_next     = dx_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        push        = 1'b0;
        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (sync)
                    begin
                        header_next = s1_item.data_byte;
                    end
                end
                PH_DELTA_X:
                begin
                    dx_next = s1_item.data_byte;
                end
                PH_DELTA_Y:
                begin
                    pos_x_next = clamp_x;
                    pos_y_next = clamp_y;
                    push       = 1'b1;
                end
                default:
                begin
                    if (sync)
                    begin
                        header_next = s1_item.data_byte;
                    end
                end
            endcase
        end
    end

    assign result.cursor_x    = clamp_x;
    assign result.cursor_y    = clamp_y;
    assign result.left_button = header_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_x_reg <= RESET_POS_X;
            pos_y_reg <= RESET_POS_Y;
            max_x_reg <= RESET_MAX_X;
            max_y_reg <= RESET_MAX_Y;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_X: max_x_reg <= cfg_data;
                    CFG_MAX_Y: max_y_reg <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        dx_reg     <= dx_next;
    end

`ifndef ASSERT_OFF
    a_push_only_third_byte: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (phase_reg == PH_DELTA_Y) && s1_item.from_mouse && !buf_full)
        else $error("result pushed outside the third mouse byte");

    a_phase_back_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (phase_reg == PH_HEADER))
        else $error("packet phase did not return to header after a result");

    a_result_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (result.cursor_x <= max_x_reg) && (result.cursor_y <= max_y_reg))
        else $error("cursor position beyond its limit");
`endif

endmodule

// ===== sv/ps2mct_out_buf.sv =====
// two-entry result buffer between the packet logic and the output channel
module ps2mct_out_buf
    import ps2mct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t result,
    output logic      buf_full,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign buf_full  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= result;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !buf_full)
        else $error("item pushed into full result buffer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");
`endif

endmodule

// ===== sv/ps2_mouse_cursor_tracker.sv =====
// top level of the ps/2 mouse cursor tracker
// Takes one controller byte per item (with a flag for the mouse port) and one item per
// clock cycle. Keyboard bytes are dropped; mouse bytes are assembled into three-byte
// packets, a packet starting only on a byte with bit 3 set. On the third byte the X
// delta is added, the Y delta subtracted, each position clamped to 0..max_x / 0..max_y,
// and one result item carries the new position and the left button bit. An item is
// held in the input register; its result is then written into the two-entry output
// buffer, from which it is offered on the output channel. The single add-and-clamp pass
// between input register and output buffer sets the rate of one item per cycle. Input
// stalls only while a third packet byte waits on a full output buffer; other bytes
// never wait. Configuration writes (index 0 max_x, index 1 max_y, others ignored)
// are always ready; the user must keep them to idle periods, as the block does not
// enforce this.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data
);

    logic      s1_valid;
    in_item_t  s1_item;
    logic      s1_take;
    logic      buf_full;
    logic      push;
    out_item_t result;

    ps2mct_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_take  (s1_take)
    );

    ps2mct_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .s1_take   (s1_take),
        .buf_full  (buf_full),
        .push      (push),
        .result    (result)
    );

    ps2mct_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .result    (result),
        .buf_full  (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
